>>> hdl/wlcg_pkg.sv
// shared constants, codes, request/status structs and the sine quarter-wave table function
// for the wavetable lfo controller generator; no dependencies
package wlcg_pkg;

	// table geometry; the table size is a power of two
	localparam int TABLE_SIZE   = 1024;
	localparam int PHASE_W      = $clog2(TABLE_SIZE);
	localparam int HALF_TABLE   = TABLE_SIZE / 2;
	localparam int QTR_BITS     = PHASE_W - 2;
	localparam int QTR_SIZE     = TABLE_SIZE / 4;

	// field widths
	localparam int ELAPSED_W    = 20;
	localparam int WAVE_W       = 2;
	localparam int RATE_W       = 17;
	localparam int DEPTH_W      = 16;
	localparam int CC_W         = 7;
	localparam int DIVIDER_W    = 7;
	localparam int CHANNEL_W    = 5;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 17;

	localparam int MIDI_CHANNEL = 1;

	// sample format, Q1.15 in 0..32768
	localparam int Q_FRAC       = 15;
	localparam int RAW_W        = Q_FRAC + 1;
	localparam logic [RAW_W-1:0] RAW_FULL = RAW_W'(1 << Q_FRAC);
	localparam logic [RAW_W-1:0] RAW_ZERO = '0;

	// value scaling: v = (depth*(raw - 63*256) + center*2^23) >> 23
	localparam int CC_OFFSET    = 63;
	localparam int CC_STEPS_LOG = 7;
	localparam int VAL_SHIFT    = 2 * Q_FRAC - CC_STEPS_LOG;
	localparam int RAW_OFFSET   = CC_OFFSET << (Q_FRAC - CC_STEPS_LOG);
	localparam int SD_W         = RAW_W + 1;
	localparam int ACC_W        = SD_W + DEPTH_W + 1;
	localparam logic [CC_W-1:0] CC_MAX = '1;

	// phase step: floor(N*rate*elapsed / (div*10^9))
	localparam int PROD_W       = RATE_W + ELAPSED_W;
	localparam int DEN_W        = PROD_W;
	localparam longint unsigned DEN_UNIT_VAL = 64'd1000000000;
	localparam logic [DEN_W-1:0] DEN_UNIT = DEN_W'(DEN_UNIT_VAL);
	// 2^29 <= 10^9, so the top 29 dividend bits never reach the divisor
	localparam int DIV_SKIP     = 29;
	localparam int DIVIDEND_W   = PROD_W + PHASE_W;
	localparam int QUOT_W       = DIVIDEND_W - DIV_SKIP;
	localparam int STEP_CNT_MAX = (RATE_W > QUOT_W) ? RATE_W : QUOT_W;
	localparam int STEP_CNT_W   = $clog2(STEP_CNT_MAX);
	localparam int SCL_CNT_W    = $clog2(DEPTH_W);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RATE       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_EXT   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_RATE  = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_DIV   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER = CFG_IDX_W'(7);

	// register reset values
	localparam logic [RATE_W-1:0]    RATE_RST   = RATE_W'(100);
	localparam logic [DEPTH_W-1:0]   DEPTH_RST  = DEPTH_W'(32768);
	localparam logic [CC_W-1:0]      CENTER_RST = CC_W'(63);
	localparam logic [DIVIDER_W-1:0] DIV_RST    = DIVIDER_W'(1);
	localparam logic [DIVIDER_W-1:0] DIV_ONE    = DIVIDER_W'(1);

	typedef enum logic [WAVE_W-1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	typedef struct packed {
		logic               load;
		logic [PHASE_W-1:0] index;
		wave_t              waveform;
	} wave_req_t;

	typedef struct packed {
		logic               start;
		logic [RAW_W-1:0]   raw;
		logic [DEPTH_W-1:0] depth;
		logic [CC_W-1:0]    center;
	} scale_req_t;

	typedef struct packed {
		logic                 start;
		logic [ELAPSED_W-1:0] elapsed;
		logic [RATE_W-1:0]    rate;
		logic [DIVIDER_W-1:0] divider;
	} step_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// sine polynomial coefficients, Q30
	localparam longint unsigned PA = 64'd1686629713;
	localparam longint unsigned PB = 64'd693598668;
	localparam longint unsigned PC = 64'd85569306;
	localparam longint unsigned PD = 64'd5026994;
	localparam longint unsigned PE = 64'd172272;
	localparam int Q30 = 30;

	// |sin| over one quarter at k/QTR_SIZE, Q1.15 capped at one; elaboration only
	function automatic logic [RAW_W-1:0] sine_quarter(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned r;
		longint unsigned s;
		x  = longint'(k) << (Q30 - QTR_BITS);
		x2 = (x * x) >> Q30;
		r  = PD - ((x2 * PE) >> Q30);
		r  = PC - ((x2 * r) >> Q30);
		r  = PB - ((x2 * r) >> Q30);
		r  = PA - ((x2 * r) >> Q30);
		s  = ((x * r) >> Q30) >> Q_FRAC;
		if (s > longint'(RAW_FULL)) begin
			s = longint'(RAW_FULL);
		end
		return RAW_W'(s);
	endfunction

	localparam logic [RAW_W-1:0] SINE_PEAK = sine_quarter(QTR_SIZE);

endpackage

>>> hdl/wlcg_tick_if.sv
// tick channel: valid/ready handshake with elapsed time and restart flag
// depends on wlcg_pkg
interface wlcg_tick_if;
	logic                           valid;
	logic                           ready;
	logic [wlcg_pkg::ELAPSED_W-1:0] elapsed_us;
	logic                           restart;

	modport source (output valid, elapsed_us, restart, input ready);
	modport sink   (input valid, elapsed_us, restart, output ready);
endinterface

>>> hdl/wlcg_msg_if.sv
// controller message channel: valid/ready handshake with channel, controller and value
// depends on wlcg_pkg
interface wlcg_msg_if;
	logic                           valid;
	logic                           ready;
	logic [wlcg_pkg::CHANNEL_W-1:0] channel;
	logic [wlcg_pkg::CC_W-1:0]      controller;
	logic [wlcg_pkg::CC_W-1:0]      cc_value;

	modport source (output valid, channel, controller, cc_value, input ready);
	modport sink   (input valid, channel, controller, cc_value, output ready);
endinterface

>>> hdl/wlcg_cfg_if.sv
// register write channel: valid/ready handshake with register index and write data
// depends on wlcg_pkg
interface wlcg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wlcg_pkg::CFG_IDX_W-1:0]  index;
	logic [wlcg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/wavetable_lfo_cc_generator.sv
// wavetable lfo controller generator: one controller message per tick transaction
// the message becomes valid once the step unit has finished: it multiplies over the rate bits,
//   divides over the quotient bits, and then the result is loaded into the output register
// a new tick is taken only once the previous result is loaded; a finished message waits in its output
//   register while the next tick is taken
// reset: arst_n clears phase, handshakes and state, and loads register defaults
module wavetable_lfo_cc_generator (
	input  logic        clk,
	input  logic        arst_n,
	wlcg_tick_if.sink   tick,
	wlcg_msg_if.source  msg,
	wlcg_cfg_if.sink    cfg
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_BUSY = 3'b010,
		T_HOLD = 3'b100
	} top_state_t;

	// configuration registers
	wlcg_pkg::wave_t                   waveform_q;
	logic [wlcg_pkg::RATE_W-1:0]       rate_q;
	logic [wlcg_pkg::DEPTH_W-1:0]      depth_q;
	logic [wlcg_pkg::CC_W-1:0]         center_q;
	logic                              sync_ext_q;
	logic [wlcg_pkg::RATE_W-1:0]       sync_rate_q;
	logic [wlcg_pkg::DIVIDER_W-1:0]    sync_div_q;
	logic [wlcg_pkg::CC_W-1:0]         ctl_num_q;

	// item state
	top_state_t                        state_q;
	logic [wlcg_pkg::PHASE_W-1:0]      phase_q;
	logic                              scl_done_q;
	logic                              stp_done_q;
	logic                              msg_vld_q;
	logic [wlcg_pkg::CC_W-1:0]         msg_ctl_q;
	logic [wlcg_pkg::CC_W-1:0]         msg_cc_q;

	logic                              accept;
	logic                              cfg_wr;
	logic                              both_done;
	logic                              out_free;
	logic                              res_load;

	wlcg_pkg::wave_req_t               wave_req;
	wlcg_pkg::scale_req_t              scl_req;
	wlcg_pkg::step_req_t               stp_req;
	wlcg_pkg::unit_sts_t               scl_sts;
	wlcg_pkg::unit_sts_t               stp_sts;
	logic [wlcg_pkg::RAW_W-1:0]        raw_s1;
	logic                              raw_vld_s1;
	logic [wlcg_pkg::CC_W-1:0]         cc_value;
	logic [wlcg_pkg::PHASE_W-1:0]      step;

	// handshakes
	assign tick.ready = (state_q == T_IDLE);
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid && cfg.ready;

	// a unit's done pulse counts in the same cycle it arrives
	assign both_done = (scl_done_q || scl_sts.done) && (stp_done_q || stp_sts.done);
	// output register is free when empty or being drained this cycle
	assign out_free  = !msg_vld_q || msg.ready;
	assign res_load  = (state_q == T_BUSY || state_q == T_HOLD) && both_done && out_free;

	// lookup uses the cleared phase on restart, from the tick transaction itself
	assign wave_req.load     = accept;
	assign wave_req.index    = tick.restart ? '0 : phase_q;
	assign wave_req.waveform = waveform_q;

	// scaling starts once the sample is registered
	assign scl_req.start  = raw_vld_s1;
	assign scl_req.raw    = raw_s1;
	assign scl_req.depth  = depth_q;
	assign scl_req.center = center_q;

	// internal rate divides by one; a zero sync divider counts as one
	assign stp_req.start   = accept;
	assign stp_req.elapsed = tick.elapsed_us;
	assign stp_req.rate    = sync_ext_q ? sync_rate_q : rate_q;
	assign stp_req.divider = !sync_ext_q ? wlcg_pkg::DIV_ONE
		: (sync_div_q == '0) ? wlcg_pkg::DIV_ONE : sync_div_q;

	wlcg_wave u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (wave_req),
		.raw_s1     (raw_s1),
		.raw_vld_s1 (raw_vld_s1)
	);

	wlcg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (scl_req),
		.sts      (scl_sts),
		.cc_value (cc_value)
	);

	wlcg_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (stp_req),
		.sts    (stp_sts),
		.step   (step)
	);

	// register writes, taken whenever offered; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= wlcg_pkg::WAVE_SINE;
			rate_q      <= wlcg_pkg::RATE_RST;
			depth_q     <= wlcg_pkg::DEPTH_RST;
			center_q    <= wlcg_pkg::CENTER_RST;
			sync_ext_q  <= 1'b0;
			sync_rate_q <= wlcg_pkg::RATE_RST;
			sync_div_q  <= wlcg_pkg::DIV_RST;
			ctl_num_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				wlcg_pkg::CFG_WAVEFORM: begin
					waveform_q <= wlcg_pkg::wave_t'(cfg.data[wlcg_pkg::WAVE_W-1:0]);
				end
				wlcg_pkg::CFG_RATE: begin
					rate_q <= cfg.data[wlcg_pkg::RATE_W-1:0];
				end
				wlcg_pkg::CFG_DEPTH: begin
					depth_q <= cfg.data[wlcg_pkg::DEPTH_W-1:0];
				end
				wlcg_pkg::CFG_CENTER: begin
					center_q <= cfg.data[wlcg_pkg::CC_W-1:0];
				end
				wlcg_pkg::CFG_SYNC_EXT: begin
					sync_ext_q <= cfg.data[0];
				end
				wlcg_pkg::CFG_SYNC_RATE: begin
					sync_rate_q <= cfg.data[wlcg_pkg::RATE_W-1:0];
				end
				wlcg_pkg::CFG_SYNC_DIV: begin
					sync_div_q <= cfg.data[wlcg_pkg::DIVIDER_W-1:0];
				end
				wlcg_pkg::CFG_CONTROLLER: begin
					ctl_num_q <= cfg.data[wlcg_pkg::CC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// item sequencing, phase and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			phase_q    <= '0;
			scl_done_q <= 1'b0;
			stp_done_q <= 1'b0;
			msg_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				scl_done_q <= 1'b0;
				stp_done_q <= 1'b0;
			end else begin
				if (scl_sts.done) begin
					scl_done_q <= 1'b1;
				end
				if (stp_sts.done) begin
					stp_done_q <= 1'b1;
				end
			end

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_BUSY;
						if (tick.restart) begin
							phase_q <= '0;
						end
					end
				end
				T_BUSY, T_HOLD: begin
					if (res_load) begin
						state_q <= T_IDLE;
					end else if (both_done) begin
						state_q <= T_HOLD;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase

			// phase wraps modulo the table size by width
			if (res_load) begin
				phase_q   <= phase_q + step;
				msg_vld_q <= 1'b1;
			end else if (msg.ready) begin
				msg_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			msg_ctl_q <= ctl_num_q;
			msg_cc_q  <= cc_value;
		end
	end

	assign msg.valid      = msg_vld_q;
	assign msg.channel    = wlcg_pkg::CHANNEL_W'(wlcg_pkg::MIDI_CHANNEL);
	assign msg.controller = msg_ctl_q;
	assign msg.cc_value   = msg_cc_q;

	// a new tick only enters when both arithmetic units have finished
	a_units_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !scl_sts.busy && !stp_sts.busy)
		else $error("tick accepted while an arithmetic unit is still working");

	// results are taken only once both units have stopped
	a_units_idle_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !scl_sts.busy && !stp_sts.busy)
		else $error("result loaded before the arithmetic units finished");

	// phase moves only at a tick or at a result load
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept && !res_load |=> $stable(phase_q))
		else $error("phase changed outside a tick or result load");

endmodule

>>> hdl/wlcg_wave.sv
// waveform sample lookup: sine quarter-wave table, square, saw and triangle, registered
// depends on wlcg_pkg
module wlcg_wave (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wlcg_pkg::wave_req_t             req,
	output logic [wlcg_pkg::RAW_W-1:0]      raw_s1,
	output logic                            raw_vld_s1
);

	localparam int SAW_SH = wlcg_pkg::RAW_W - 1 - wlcg_pkg::PHASE_W;
	localparam int TRI_SH = wlcg_pkg::RAW_W - wlcg_pkg::PHASE_W;

	logic [wlcg_pkg::RAW_W-1:0]    sine_rom [wlcg_pkg::QTR_SIZE];
	logic [1:0]                    quad;
	logic [wlcg_pkg::QTR_BITS-1:0] qidx;
	logic [wlcg_pkg::QTR_BITS-1:0] ridx;
	logic                          peak;
	logic                          upper;
	logic [wlcg_pkg::RAW_W-1:0]    mag;
	logic [wlcg_pkg::RAW_W:0]      sum_hi;
	logic [wlcg_pkg::RAW_W:0]      sum_lo;
	logic [wlcg_pkg::PHASE_W-1:0]  tri_idx;
	logic [wlcg_pkg::RAW_W-1:0]    raw;

	for (genvar g = 0; g < wlcg_pkg::QTR_SIZE; g++) begin : g_rom
		assign sine_rom[g] = wlcg_pkg::sine_quarter(g);
	end

	// quadrant symmetry: odd quadrants read the quarter backwards
	assign quad   = req.index[wlcg_pkg::PHASE_W-1 -: 2];
	assign qidx   = req.index[wlcg_pkg::QTR_BITS-1:0];
	assign ridx   = quad[0] ? (~qidx + 1'b1) : qidx;
	assign peak   = quad[0] && (qidx == '0);
	assign mag    = peak ? wlcg_pkg::SINE_PEAK : sine_rom[ridx];
	assign sum_hi = {1'b0, wlcg_pkg::RAW_FULL} + {1'b0, mag};
	assign sum_lo = {1'b0, wlcg_pkg::RAW_FULL} - {1'b0, mag};

	assign upper   = req.index > wlcg_pkg::PHASE_W'(wlcg_pkg::HALF_TABLE);
	assign tri_idx = upper ? (~req.index + 1'b1) : req.index;

	always_comb begin
		unique case (req.waveform)
			wlcg_pkg::WAVE_SINE: begin
				raw = quad[1] ? sum_lo[wlcg_pkg::RAW_W:1] : sum_hi[wlcg_pkg::RAW_W:1];
			end
			wlcg_pkg::WAVE_SQUARE: begin
				raw = upper ? wlcg_pkg::RAW_FULL : wlcg_pkg::RAW_ZERO;
			end
			wlcg_pkg::WAVE_SAW: begin
				raw = {1'b0, req.index, {SAW_SH{1'b0}}};
			end
			wlcg_pkg::WAVE_TRIANGLE: begin
				raw = {tri_idx, {TRI_SH{1'b0}}};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_vld_s1 <= 1'b0;
		end else begin
			raw_vld_s1 <= req.load;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			raw_s1 <= raw;
		end
	end

endmodule

>>> hdl/wlcg_scale.sv
// depth and centre scaling: bit-serial signed multiply by depth, then offset and clamp
// depends on wlcg_pkg
module wlcg_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wlcg_pkg::scale_req_t       req,
	output wlcg_pkg::unit_sts_t        sts,
	output logic [wlcg_pkg::CC_W-1:0]  cc_value
);

	typedef enum logic [2:0] {
		SC_IDLE = 3'b001,
		SC_MUL  = 3'b010,
		SC_FIN  = 3'b100
	} scl_state_t;

	localparam int SD_W  = wlcg_pkg::SD_W;
	localparam int ACC_W = wlcg_pkg::ACC_W;
	localparam int VS    = wlcg_pkg::VAL_SHIFT;

	scl_state_t                     state_q;
	logic [wlcg_pkg::SCL_CNT_W-1:0] cnt_q;
	logic signed [SD_W-1:0]         sd_q;
	logic [wlcg_pkg::DEPTH_W-1:0]   depth_q;
	logic [wlcg_pkg::CC_W-1:0]      center_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        acc_nxt;
	logic signed [ACC_W-1:0]        sum;
	logic [wlcg_pkg::CC_W-1:0]      val;
	logic                           done_q;

	// msb-first shift-and-add over the depth bits
	assign acc_nxt = (acc_q <<< 1)
		+ (depth_q[wlcg_pkg::DEPTH_W-1] ? {{(ACC_W-SD_W){sd_q[SD_W-1]}}, sd_q} : '0);

	assign sum = acc_q + $signed({{(ACC_W-wlcg_pkg::CC_W-VS){1'b0}}, center_q, {VS{1'b0}}});

	always_comb begin
		priority if (sum[ACC_W-1]) begin
			val = '0;
		end else if (|sum[ACC_W-2:VS+wlcg_pkg::CC_W]) begin
			val = wlcg_pkg::CC_MAX;
		end else begin
			val = sum[VS+wlcg_pkg::CC_W-1:VS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						state_q <= SC_MUL;
						cnt_q   <= '0;
					end
				end
				SC_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wlcg_pkg::SCL_CNT_W'(wlcg_pkg::DEPTH_W - 1)) begin
						state_q <= SC_FIN;
					end
				end
				SC_FIN: begin
					state_q <= SC_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && req.start) begin
			sd_q     <= $signed({1'b0, req.raw}) - SD_W'(wlcg_pkg::RAW_OFFSET);
			depth_q  <= req.depth;
			center_q <= req.center;
			acc_q    <= '0;
		end else if (state_q == SC_MUL) begin
			acc_q   <= acc_nxt;
			depth_q <= {depth_q[wlcg_pkg::DEPTH_W-2:0], 1'b0};
		end else if (state_q == SC_FIN) begin
			cc_value <= val;
		end
	end

	assign sts.busy = (state_q != SC_IDLE);
	assign sts.done = done_q;

endmodule

>>> hdl/wlcg_step.sv
// phase step: bit-serial rate*elapsed multiply, then restoring divide by divider*10^9,
// quotient kept modulo the table size; depends on wlcg_pkg
module wlcg_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wlcg_pkg::step_req_t           req,
	output wlcg_pkg::unit_sts_t           sts,
	output logic [wlcg_pkg::PHASE_W-1:0]  step
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_DIV  = 3'b100
	} stp_state_t;

	localparam int PW = wlcg_pkg::PROD_W;
	localparam int DW = wlcg_pkg::DEN_W;
	localparam int QW = wlcg_pkg::QUOT_W;
	localparam int VW = wlcg_pkg::DIVIDEND_W;

	stp_state_t                          state_q;
	logic [wlcg_pkg::STEP_CNT_W-1:0]     cnt_q;
	logic [wlcg_pkg::RATE_W-1:0]         rate_q;
	logic [wlcg_pkg::ELAPSED_W-1:0]      elap_q;
	logic [PW-1:0]                       prod_q;
	logic [PW-1:0]                       prod_nxt;
	logic [VW-1:0]                       dvd;
	logic [DW-1:0]                       den_q;
	logic [DW-1:0]                       rem_q;
	logic [QW-1:0]                       dq_q;
	logic [wlcg_pkg::PHASE_W-1:0]        quot_q;
	logic [DW:0]                         trial;
	logic                                ge;
	logic                                done_q;

	assign prod_nxt = {prod_q[PW-2:0], 1'b0}
		+ (rate_q[wlcg_pkg::RATE_W-1] ? PW'(elap_q) : '0);
	// times table size is a left shift
	assign dvd   = {prod_nxt, {wlcg_pkg::PHASE_W{1'b0}}};
	assign trial = {rem_q, dq_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == wlcg_pkg::STEP_CNT_W'(wlcg_pkg::RATE_W - 1)) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == wlcg_pkg::STEP_CNT_W'(QW - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					rate_q <= req.rate;
					elap_q <= req.elapsed;
					den_q  <= DW'(req.divider) * wlcg_pkg::DEN_UNIT;
					prod_q <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= prod_nxt;
				rate_q <= {rate_q[wlcg_pkg::RATE_W-2:0], 1'b0};
				if (cnt_q == wlcg_pkg::STEP_CNT_W'(wlcg_pkg::RATE_W - 1)) begin
					// leading dividend bits sit below the divisor, preload them
					rem_q  <= DW'(dvd[VW-1:QW]);
					dq_q   <= dvd[QW-1:0];
					quot_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
				dq_q   <= {dq_q[QW-2:0], 1'b0};
				quot_q <= {quot_q[wlcg_pkg::PHASE_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.done = done_q;
	assign step     = quot_q;

endmodule

>>> dv/tb_wavetable_lfo_cc_generator.sv
// self-checking testbench for wavetable_lfo_cc_generator: directed table then random phases,
// every controller message checked against a cycle-free model of the lfo
// depends on wlcg_pkg, the three channel interfaces and the rtl top level
module tb_wavetable_lfo_cc_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import wlcg_pkg::*;

	typedef longint unsigned u64_t;

	// controller message as it leaves the block
	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic [CC_W-1:0]      controller;
		logic [CC_W-1:0]      cc_value;
	} cc_msg_t;

	// one line of the directed table: a register write or a tick
	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [ELAPSED_W-1:0]  elapsed;
		logic                  restart;
		int                    want_cc;   // -1: left to the model
	} plan_row_t;

	// indexes past the last register, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(8);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = CFG_IDX_W'(15);
	localparam int NUM_REGS = 8;

	// lfo arithmetic constants
	localparam u64_t Q30_UNIT       = 64'd1073741824;
	localparam u64_t SIN_A          = 64'd1686629713;
	localparam u64_t SIN_B          = 64'd693598668;
	localparam u64_t SIN_C          = 64'd85569306;
	localparam u64_t SIN_D          = 64'd5026994;
	localparam u64_t SIN_E          = 64'd172272;
	localparam u64_t FULL_SCALE     = 64'd32768;
	localparam u64_t CENTRE_OFFSET  = 64'd63;
	localparam u64_t MHZ_US_PER_REV = 64'd1000000000;   // mHz times us per cycle

	// run shape
	localparam int LATENCY_CYCLES  = 36;
	localparam int DRAIN_CYCLES    = 2 * LATENCY_CYCLES;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int LONG_HOLD       = 600;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic clk = 1'b0;
	logic arst_n;

	wlcg_tick_if tick_ch();
	wlcg_msg_if  msg_ch();
	wlcg_cfg_if  cfg_ch();

	wavetable_lfo_cc_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.msg    (msg_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// model state, starts at the reset values of the block
	wave_t                lfo_wave       = WAVE_SINE;
	logic [RATE_W-1:0]    lfo_rate       = 17'd100;
	logic [DEPTH_W-1:0]   lfo_depth      = 16'd32768;
	logic [CC_W-1:0]      lfo_center     = 7'd63;
	logic                 lfo_sync       = 1'b0;
	logic [RATE_W-1:0]    lfo_sync_rate  = 17'd100;
	logic [DIVIDER_W-1:0] lfo_sync_div   = 7'd1;
	logic [CC_W-1:0]      lfo_controller = 7'd0;
	logic [PHASE_W-1:0]   lfo_phase      = '0;

	cc_msg_t   expected_cc[$];   // predicted messages, oldest first
	int        typed_cc_q[$];    // per tick: hand-typed cc value or -1
	plan_row_t plan[$];

	int mismatches     = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_requests  = 0;
	int quiet_cycles   = 0;

	// ---------------------------------------------------------------- model

	// sin(pi/2 x) for x in Q30, odd polynomial, each product truncated
	function automatic u64_t sine_q30(input u64_t x);
		u64_t xx;
		u64_t acc;
		xx  = (x * x) >> 30;
		acc = SIN_D - ((xx * SIN_E) >> 30);
		acc = SIN_C - ((xx * acc) >> 30);
		acc = SIN_B - ((xx * acc) >> 30);
		acc = SIN_A - ((xx * acc) >> 30);
		return (x * acc) >> 30;
	endfunction

	// Q1.15 table sample, 0..32768
	function automatic u64_t wave_sample(input wave_t w, input logic [PHASE_W-1:0] idx);
		u64_t n;
		u64_t i;
		u64_t t;
		u64_t quad;
		u64_t frac;
		u64_t s;
		n = TABLE_SIZE;
		i = idx;
		case (w)
			WAVE_SINE: begin
				t    = ((i * 4) << 30) / n;
				quad = (t >> 30) & 3;
				frac = t & (Q30_UNIT - 1);
				// odd quadrants run the polynomial backwards
				s = sine_q30(quad[0] ? (Q30_UNIT - frac) : frac) >> 15;
				if (s > FULL_SCALE) s = FULL_SCALE;
				return (quad < 2) ? ((FULL_SCALE + s) >> 1) : ((FULL_SCALE - s) >> 1);
			end
			WAVE_SQUARE: return (i <= n / 2) ? 0 : FULL_SCALE;
			WAVE_SAW:    return (i * FULL_SCALE) / n;
			default:     return (i <= n / 2) ? ((i * 65536) / n) : (((n - i) * 65536) / n);
		endcase
	endfunction

	// one tick: lookup, scale and clamp, then advance the phase
	function automatic cc_msg_t lfo_tick(input logic [ELAPSED_W-1:0] el, input logic rs);
		u64_t    n;
		u64_t    raw;
		u64_t    dep;
		u64_t    ctr;
		u64_t    rate;
		u64_t    den;
		u64_t    advance;
		longint  acc;
		cc_msg_t m;
		n = TABLE_SIZE;
		if (rs) lfo_phase = '0;
		raw = wave_sample(lfo_wave, lfo_phase);
		dep = lfo_depth;
		ctr = lfo_center;
		acc = $signed(raw * dep * 128) - $signed(dep * CENTRE_OFFSET * FULL_SCALE)
			+ $signed(ctr << 30);
		if (acc < 0) begin
			m.cc_value = '0;
		end else if ((acc >>> 30) > 127) begin
			m.cc_value = '1;
		end else begin
			m.cc_value = CC_W'(acc >>> 30);
		end
		m.channel    = CHANNEL_W'(MIDI_CHANNEL);
		m.controller = lfo_controller;
		// a zero divider counts as one
		rate = lfo_sync ? u64_t'(lfo_sync_rate) : u64_t'(lfo_rate);
		den  = (!lfo_sync || lfo_sync_div == '0) ? 1 : u64_t'(lfo_sync_div);
		advance   = (n * rate * u64_t'(el)) / (den * MHZ_US_PER_REV);
		lfo_phase = PHASE_W'((u64_t'(lfo_phase) + advance) % n);
		return m;
	endfunction

	// register write, masked to the field width; unknown indexes do nothing
	function automatic void lfo_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_WAVEFORM:   lfo_wave       = wave_t'(val[WAVE_W-1:0]);
			CFG_RATE:       lfo_rate       = val[RATE_W-1:0];
			CFG_DEPTH:      lfo_depth      = val[DEPTH_W-1:0];
			CFG_CENTER:     lfo_center     = val[CC_W-1:0];
			CFG_SYNC_EXT:   lfo_sync       = val[0];
			CFG_SYNC_RATE:  lfo_sync_rate  = val[RATE_W-1:0];
			CFG_SYNC_DIV:   lfo_sync_div   = val[DIVIDER_W-1:0];
			CFG_CONTROLLER: lfo_controller = val[CC_W-1:0];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0d ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// all three channels sampled at the edge, before the drivers' updates land
	always @(posedge clk) begin : scoreboard
		cc_msg_t want;
		int      typed;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) lfo_write(cfg_ch.index, cfg_ch.data);
			if (msg_ch.valid && msg_ch.ready) begin
				if (expected_cc.size() == 0) begin
					$display("%0d ns: unexpected message, expected none, got cc %0d value %0d",
						$time, msg_ch.controller, msg_ch.cc_value);
					mismatches++;
				end else begin
					want = expected_cc.pop_front();
					check_field("channel", want.channel, msg_ch.channel);
					check_field("controller", want.controller, msg_ch.controller);
					check_field("cc_value", want.cc_value, msg_ch.cc_value);
				end
			end
			if (tick_ch.valid && tick_ch.ready) begin
				want  = lfo_tick(tick_ch.elapsed_us, tick_ch.restart);
				typed = typed_cc_q.pop_front();
				// hand-typed rows override the model's value, state still advances
				if (typed >= 0) want.cc_value = CC_W'(typed);
				expected_cc.push_back(want);
			end
		end
	end

	// ends the run when no transaction moves for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (msg_ch.valid && msg_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// ---------------------------------------------------------------- message sink

	// random stalls, plus a long hold-off each time the stimulus asks for one
	initial begin : msg_sink
		int seen;
		int hold_left;
		seen      = 0;
		hold_left = 0;
		msg_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen) begin
				seen      = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				msg_ch.ready <= 1'b0;
			end else begin
				msg_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// valid is left high on return; the next call or the caller lowers it
	task automatic send_tick(input logic [ELAPSED_W-1:0] el, input logic rs, input int want);
		while ($urandom_range(99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		typed_cc_q.push_back(want);
		tick_ch.valid      <= 1'b1;
		tick_ch.elapsed_us <= el;
		tick_ch.restart    <= rs;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// lower tick valid and wait for every outstanding message
	task automatic drain_ticks();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_cc.size() != 0);
	endtask

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r.is_cfg  = 1'b1;
		r.idx     = idx;
		r.data    = val;
		r.elapsed = '0;
		r.restart = 1'b0;
		r.want_cc = -1;
		plan.push_back(r);
	endfunction

	function automatic void plan_tick(input logic [ELAPSED_W-1:0] el, input logic rs,
			input int want = -1);
		plan_row_t r;
		r.is_cfg  = 1'b0;
		r.idx     = '0;
		r.data    = '0;
		r.elapsed = el;
		r.restart = rs;
		r.want_cc = want;
		plan.push_back(r);
	endfunction

	// in-range value most of the time, any bit pattern now and then
	function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
		if ($urandom_range(3) == 0) return CFG_DATA_W'($urandom());
		case (idx)
			CFG_WAVEFORM:                 return CFG_DATA_W'($urandom_range(3));
			CFG_RATE, CFG_SYNC_RATE:      return CFG_DATA_W'($urandom_range(100000));
			CFG_DEPTH:                    return CFG_DATA_W'($urandom_range(32768));
			CFG_CENTER, CFG_CONTROLLER:   return CFG_DATA_W'($urandom_range(127));
			CFG_SYNC_EXT:                 return CFG_DATA_W'($urandom_range(1));
			CFG_SYNC_DIV:                 return CFG_DATA_W'($urandom_range(64, 1));
			default:                      return CFG_DATA_W'($urandom());
		endcase
	endfunction

	function automatic logic [ELAPSED_W-1:0] pick_elapsed();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) return ELAPSED_W'($urandom_range(20000));
		if (pick < 8) return ELAPSED_W'($urandom_range(1000000));
		return ELAPSED_W'($urandom());
	endfunction

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		bit                    in_cfg;
		logic [CFG_DATA_W-1:0] val;
		tick_ch.valid      <= 1'b0;
		tick_ch.elapsed_us <= '0;
		tick_ch.restart    <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		arst_n             <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed values are the obvious ones
		plan_tick(20'd0, 1'b0, 64);                  // reset state, sine at phase zero
		plan_tick(20'd1000000, 1'b0);                // default rate over one second
		plan_tick(20'd20000, 1'b1, 64);              // restart back to phase zero
		plan_cfg(CFG_RATE, 17'd100000);              // quarter table per 2500 us
		plan_tick(20'd2500, 1'b1, 64);
		plan_tick(20'd2500, 1'b0, 127);              // sine peak
		plan_tick(20'd2500, 1'b0, 64);               // sine mid crossing
		plan_tick(20'd2500, 1'b0, 0);                // sine trough
		plan_tick(20'd1234, 1'b0);                   // starts from the phase that wrapped past the table end
		plan_cfg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
		plan_cfg(CFG_CENTER, 17'd0);
		plan_tick(20'd6000, 1'b1, 0);                // clamped at the bottom
		plan_cfg(CFG_CENTER, 17'd127);
		plan_tick(20'd0, 1'b0, 127);                 // clamped at the top
		plan_cfg(CFG_DEPTH, 17'd0);
		plan_tick(20'd0, 1'b0, 127);                 // no depth, centre only
		plan_cfg(CFG_DEPTH, 17'h0ffff);              // gain above one
		plan_cfg(CFG_CENTER, 17'd40);
		plan_tick(20'd5000, 1'b0);
		plan_tick(20'd0, 1'b1);
		plan_cfg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW));
		plan_cfg(CFG_DEPTH, 17'd32768);
		plan_cfg(CFG_CENTER, 17'd63);
		plan_tick(20'hfffff, 1'b1, 0);               // widest elapsed time
		plan_tick(20'd777, 1'b0);
		plan_cfg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_TRIANGLE));
		plan_tick(20'd5000, 1'b0);
		plan_tick(20'd2500, 1'b0);
		plan_cfg(CFG_SYNC_EXT, 17'd1);
		plan_cfg(CFG_SYNC_RATE, 17'h1ffff);
		plan_cfg(CFG_SYNC_DIV, 17'd0);               // zero divider acts as one
		plan_tick(20'hfffff, 1'b0);
		plan_tick(20'd4321, 1'b0);
		plan_cfg(CFG_SYNC_DIV, 17'h0007f);           // divider beyond its range
		plan_tick(20'd999999, 1'b0);
		plan_cfg(CFG_SYNC_DIV, 17'd64);
		plan_cfg(CFG_SYNC_RATE, 17'd0);
		plan_tick(20'd1000000, 1'b0);
		plan_cfg(CFG_SPARE_FIRST, 17'h1ffff);        // unknown indexes are dropped
		plan_cfg(CFG_SPARE_LAST, 17'h00155);
		plan_cfg(CFG_CONTROLLER, 17'd127);
		plan_cfg(CFG_WAVEFORM, 17'h1fffc);           // upper bits masked, sine
		plan_cfg(CFG_SYNC_EXT, 17'h1fffe);           // upper bits masked, internal
		plan_cfg(CFG_RATE, 17'h1ffff);               // rate beyond its range
		plan_tick(20'hfffff, 1'b1, 64);
		plan_tick(20'hfffff, 1'b0);
		plan_tick(20'd0, 1'b0);

		// registers only change once every message is out
		in_cfg = 1'b0;
		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				if (!in_cfg) drain_ticks();
				in_cfg = 1'b1;
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				if (in_cfg) cfg_ch.valid <= 1'b0;
				in_cfg = 1'b0;
				send_tick(plan[r].elapsed, plan[r].restart, plan[r].want_cc);
			end
		end

		// random phases, each with its own register set and idling pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_ticks();
			case (p % 4)
				0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
				2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
				default: begin src_idle_pct = 11; sink_stall_pct = 11; end
			endcase
			for (int k = 0; k < NUM_REGS; k++) begin
				if (p == 2) begin
					val = '1;                        // every field at its top
				end else if (p == 5) begin
					// bottom of the other fields, with sync on at rate 100000, full depth and the zero divider
					if (k == CFG_SYNC_EXT) val = 17'd1;
					else if (k == CFG_SYNC_RATE) val = 17'd100000;
					else if (k == CFG_DEPTH) val = 17'd32768;
					else val = '0;
				end else begin
					val = pick_reg(CFG_IDX_W'(k));
				end
				write_reg(CFG_IDX_W'(k), val);
			end
			if ($urandom_range(1) == 1)
				write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
					CFG_DATA_W'($urandom()));
			cfg_ch.valid <= 1'b0;

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// sink holds off while ticks keep coming, so the block backs up
				if (p == 0 && k == 8) hold_requests++;
				// sender waits for the block to empty mid-phase
				if (p == 4 && k == 32) drain_ticks();
				send_tick(pick_elapsed(), ($urandom_range(9) == 0), -1);
			end
		end

		drain_ticks();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_cc.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
